// ===== rtl/core/sotq_pkg.sv =====
// ----------------------------------------------------------------------------
// sotq_pkg
// Shared types and constants of the sorted one-shot timer queue.
// ----------------------------------------------------------------------------
package sotq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // item kinds carried on in_tuser
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_MODIFY = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // one result word
  typedef struct packed {
    logic        status;
    logic        was_pending;
    logic        restart;
    logic        fired;
    logic [3:0]  fired_id;
    logic [31:0] fired_word;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/sorted_oneshot_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_oneshot_timer_queue_unit
// Add/modify scan the list entries for the insert point, then shift entries in
// the order memory to open a gap; locating a timer to detach (modify, delete)
// scans the list, then closes the gap. A tick reads the head and detaches each
// expired timer in turn, shifting the remaining entries.
// One word is worked on at a time; the single order-memory port sets the pace.
// Reset (synchronous, rst_n low) empties the list and clears pending flags.
// ----------------------------------------------------------------------------
module sorted_oneshot_timer_queue_unit
  import sotq_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] timer_id, [35:4] expiry_time, [67:36] user_word, [99:68] now_ticks
  input  logic [103:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] status, [1] was_pending, [2] restart, [6:3] fired_id, [38:7] fired_word
  output logic [39:0]  out_tdata,
  // [0] fired
  output logic         out_tuser,
  output logic         out_tlast
);

  localparam int IDW = $clog2(NUM_TIMERS);
  localparam int CW  = $clog2(NUM_TIMERS + 1);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_INS_RDO = 14'b00000000000010,
    S_INS_RDE = 14'b00000000000100,
    S_INS_CMP = 14'b00000000001000,
    S_SHF_RD  = 14'b00000000010000,
    S_SHF_WR  = 14'b00000000100000,
    S_DET_RDO = 14'b00000001000000,
    S_DET_CMP = 14'b00000010000000,
    S_DET_RD  = 14'b00000100000000,
    S_DET_WR  = 14'b00001000000000,
    S_TK_RDO  = 14'b00010000000000,
    S_TK_RDE  = 14'b00100000000000,
    S_TK_CMP  = 14'b01000000000000,
    S_EMIT    = 14'b10000000000000
  } state_t;

  // input unpack
  logic [3:0]           in_id;
  logic [31:0]          in_exp, in_word, in_now;
  logic                 in_id_ok;
  logic [IDW-1:0]       in_idx;
  logic                 in_acc;

  assign in_id    = in_tdata[3:0];
  assign in_exp   = in_tdata[35:4];
  assign in_word  = in_tdata[67:36];
  assign in_now   = in_tdata[99:68];
  assign in_id_ok = (32'(in_id) < NUM_TIMERS);
  assign in_idx   = IDW'(in_id);

  // registers
  state_t               state_r, state_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [IDW-1:0]       id_r, id_nxt;
  logic [TIME_BITS-1:0] tm_r, tm_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 wp_r, wp_nxt;
  logic                 held_r, held_nxt;
  logic [3:0]           hid_r, hid_nxt;
  logic [31:0]          hword_r, hword_nxt;
  res_t                 res_r, res_nxt;
  logic [NUM_TIMERS-1:0] pend_r;
  logic                 pend_set, pend_clr;
  logic                 out_valid_r;
  res_t                 out_r, out_nxt;
  logic                 out_load, out_free;

  // memories
  logic [IDW-1:0]       ord_mem [NUM_TIMERS];
  logic [TIME_BITS-1:0] exp_mem [NUM_TIMERS];
  logic [31:0]          wrd_mem [NUM_TIMERS];
  logic [IDW-1:0]       ord_rd_r, ord_raddr, ord_waddr, ord_wdata;
  logic                 ord_we;
  logic [TIME_BITS-1:0] exp_rd_r, exp_wdata;
  logic [31:0]          wrd_rd_r;
  logic [IDW-1:0]       exp_raddr, exp_waddr;
  logic                 exp_we, wrd_we;

  // tick compare: expired when expiry minus now is not positive
  logic [TIME_BITS-1:0] diff;
  logic                 expired;
  assign diff    = exp_rd_r - tm_r;
  assign expired = (diff == '0) || diff[TIME_BITS-1];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rd_r <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (exp_we) exp_mem[exp_waddr] <= exp_wdata;
    if (wrd_we) wrd_mem[exp_waddr] <= in_word;
    exp_rd_r <= exp_mem[exp_raddr];
    wrd_rd_r <= wrd_mem[exp_raddr];
  end

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    id_nxt    = id_r;
    tm_nxt    = tm_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    wp_nxt    = wp_r;
    held_nxt  = held_r;
    hid_nxt   = hid_r;
    hword_nxt = hword_r;
    res_nxt   = res_r;
    pend_set  = 1'b0;
    pend_clr  = 1'b0;
    out_load  = 1'b0;
    out_nxt   = res_r;
    ord_raddr = pos_r[IDW-1:0];
    ord_we    = 1'b0;
    ord_waddr = i_r[IDW-1:0];
    ord_wdata = ord_rd_r;
    exp_raddr = id_r;
    exp_waddr = in_idx;
    exp_wdata = TIME_BITS'(in_exp);
    exp_we    = 1'b0;
    wrd_we    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_tuser;
          id_nxt   = in_idx;
          pos_nxt  = '0;
          res_nxt  = '0;
          res_nxt.last = 1'b1;
          case (in_tuser)
            KIND_ADD: begin
              if (!in_id_ok || pend_r[in_idx]) begin
                res_nxt.status = 1'b1;
                state_nxt = S_EMIT;
              end else begin
                exp_we    = 1'b1;
                wrd_we    = 1'b1;
                tm_nxt    = TIME_BITS'(in_exp);
                wp_nxt    = 1'b0;
                state_nxt = S_INS_RDO;
              end
            end
            KIND_MODIFY: begin
              if (!in_id_ok) begin
                state_nxt = S_EMIT;
              end else begin
                exp_we    = 1'b1;
                tm_nxt    = TIME_BITS'(in_exp);
                wp_nxt    = pend_r[in_idx];
                state_nxt = pend_r[in_idx] ? S_DET_RDO : S_INS_RDO;
              end
            end
            KIND_DELETE: begin
              if (!in_id_ok || !pend_r[in_idx]) state_nxt = S_EMIT;
              else state_nxt = S_DET_RDO;
            end
            default: begin
              tm_nxt    = TIME_BITS'(in_now);
              held_nxt  = 1'b0;
              state_nxt = S_TK_RDO;
            end
          endcase
        end
      end

      // sorted insert: find first entry with later expiry
      S_INS_RDO: begin
        if (pos_r == cnt_r) begin
          i_nxt     = cnt_r;
          state_nxt = S_SHF_RD;
        end else begin
          state_nxt = S_INS_RDE;
        end
      end
      S_INS_RDE: begin
        exp_raddr = ord_rd_r;
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (exp_rd_r <= tm_r) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_INS_RDO;
        end else begin
          i_nxt     = cnt_r;
          state_nxt = S_SHF_RD;
        end
      end

      // open a gap at pos by moving entries down one place
      S_SHF_RD: begin
        ord_raddr = IDW'(i_r - 1'b1);
        if (i_r == pos_r) begin
          ord_we    = 1'b1;
          ord_waddr = pos_r[IDW-1:0];
          ord_wdata = id_r;
          cnt_nxt   = cnt_r + 1'b1;
          pend_set  = 1'b1;
          res_nxt   = '0;
          res_nxt.was_pending = wp_r;
          res_nxt.restart     = (pos_r == '0);
          res_nxt.last        = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        ord_we    = 1'b1;
        i_nxt     = i_r - 1'b1;
        state_nxt = S_SHF_RD;
      end

      // detach: locate id, then close the gap
      S_DET_RDO: begin
        state_nxt = S_DET_CMP;
      end
      S_DET_CMP: begin
        if (ord_rd_r == id_r) begin
          i_nxt     = pos_r;
          state_nxt = S_DET_RD;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_DET_RDO;
        end
      end
      S_DET_RD: begin
        ord_raddr = IDW'(i_r + 1'b1);
        if (CW'(i_r + 1'b1) == cnt_r) begin
          cnt_nxt  = cnt_r - 1'b1;
          pend_clr = 1'b1;
          pos_nxt  = '0;
          case (kind_r)
            KIND_MODIFY: state_nxt = S_INS_RDO;
            KIND_TICK:   state_nxt = S_TK_RDO;
            default: begin
              res_nxt   = '0;
              res_nxt.was_pending = 1'b1;
              res_nxt.last        = 1'b1;
              state_nxt = S_EMIT;
            end
          endcase
        end else begin
          state_nxt = S_DET_WR;
        end
      end
      S_DET_WR: begin
        ord_we    = 1'b1;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_DET_RD;
      end

      // tick: check the head, pop while expired
      S_TK_RDO: begin
        ord_raddr = '0;
        if (cnt_r == '0) begin
          res_nxt   = '0;
          res_nxt.last = 1'b1;
          if (held_r) begin
            res_nxt.fired      = 1'b1;
            res_nxt.fired_id   = hid_r;
            res_nxt.fired_word = hword_r;
          end
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_TK_RDE;
        end
      end
      S_TK_RDE: begin
        exp_raddr = ord_rd_r;
        id_nxt    = ord_rd_r;
        state_nxt = S_TK_CMP;
      end
      S_TK_CMP: begin
        if (expired) begin
          if (!held_r || out_free) begin
            out_nxt            = '0;
            out_nxt.fired      = 1'b1;
            out_nxt.fired_id   = hid_r;
            out_nxt.fired_word = hword_r;
            out_load  = held_r;
            held_nxt  = 1'b1;
            hid_nxt   = 4'(id_r);
            hword_nxt = wrd_rd_r;
            i_nxt     = '0;
            state_nxt = S_DET_RD;
          end
        end else begin
          res_nxt   = '0;
          res_nxt.last = 1'b1;
          if (held_r) begin
            res_nxt.fired      = 1'b1;
            res_nxt.fired_id   = hid_r;
            res_nxt.fired_word = hword_r;
          end
          state_nxt = S_EMIT;
        end
      end

      // hand the final result to the output register
      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= '0;
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
      if (pend_set) pend_r[id_r] <= 1'b1;
      if (pend_clr) pend_r[id_r] <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    id_r    <= id_nxt;
    tm_r    <= tm_nxt;
    pos_r   <= pos_nxt;
    i_r     <= i_nxt;
    wp_r    <= wp_nxt;
    hid_r   <= hid_nxt;
    hword_r <= hword_nxt;
    res_r   <= res_nxt;
    if (out_load) out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.fired_word, out_r.fired_id, out_r.restart,
                       out_r.was_pending, out_r.status};
  assign out_tuser  = out_r.fired;
  assign out_tlast  = out_r.last;

endmodule

// ===== tb/sotq_checker.sv =====
// ----------------------------------------------------------------------------
// sotq_checker
// Watches both streams of the timer queue, keeps its own sorted timer list,
// predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module sotq_checker
  import sotq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [39:0]  out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  output int           err_count,
  output int           pending_results,
  output int           fired_total
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = 16;

  logic [3:0]  list_ids [NT];
  int          list_len;
  logic [31:0] exp_mem  [NT];
  logic [31:0] word_mem [NT];
  logic        armed    [NT];
  res_t        want_q[$];

  // remove a slot from the sorted list; returns whether it was queued
  function automatic logic unlink(input logic [3:0] id);
    int p;
    if (!armed[id]) return 1'b0;
    p = 0;
    while (p < list_len && list_ids[p] != id) p++;
    if (p < list_len) begin
      for (int i = p; i + 1 < list_len; i++) list_ids[i] = list_ids[i + 1];
      list_len--;
    end
    armed[id] = 1'b0;
    return 1'b1;
  endfunction

  // sorted insert after equal or earlier expiries; returns head flag
  function automatic logic link(input logic [3:0] id);
    int p;
    if (list_len >= NT) return 1'b0;
    p = 0;
    while (p < list_len && exp_mem[list_ids[p]] <= exp_mem[id]) p++;
    for (int i = list_len; i > p; i--) list_ids[i] = list_ids[i - 1];
    list_ids[p] = id;
    list_len++;
    armed[id] = 1'b1;
    return p == 0;
  endfunction

  task automatic predict_word(input logic [1:0] kind, input logic [103:0] d);
    logic [3:0]  id;
    logic [31:0] ex, wd, now, diff;
    res_t        r;
    int          n;
    id  = d[3:0];
    ex  = d[35:4];
    wd  = d[67:36];
    now = d[99:68];
    r = '0;
    r.last = 1'b1;
    case (kind)
      KIND_ADD: begin
        if (armed[id]) r.status = 1'b1;
        else begin
          exp_mem[id] = ex;
          word_mem[id] = wd;
          r.restart = link(id);
        end
        want_q.push_back(r);
      end
      KIND_MODIFY: begin
        exp_mem[id] = ex;
        r.was_pending = unlink(id);
        r.restart = link(id);
        want_q.push_back(r);
      end
      KIND_DELETE: begin
        r.was_pending = unlink(id);
        want_q.push_back(r);
      end
      default: begin
        n = 0;
        while (list_len > 0 && n < NT) begin
          id = list_ids[0];
          diff = exp_mem[id] - now;
          if (diff != 0 && !diff[31]) break;
          void'(unlink(id));
          r = '0;
          r.fired = 1'b1;
          r.fired_id = id;
          r.fired_word = word_mem[id];
          want_q.push_back(r);
          n++;
        end
        if (n == 0) want_q.push_back(r);
        else want_q[$].last = 1'b1;
        fired_total += n;
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      list_len = 0;
      for (int i = 0; i < NT; i++) begin
        armed[i] = 1'b0;
        exp_mem[i] = '0;
        word_mem[i] = '0;
      end
      want_q.delete();
      err_count <= 0;
      fired_total = 0;
    end else begin
      if (in_tvalid && in_tready) predict_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got.status      = out_tdata[0];
        got.was_pending = out_tdata[1];
        got.restart     = out_tdata[2];
        got.fired_id    = out_tdata[6:3];
        got.fired_word  = out_tdata[38:7];
        got.fired       = out_tuser;
        got.last        = out_tlast;
        if (want_q.size() == 0) begin
          if (err_count < 10) $display("unexpected result word %h", got);
          err_count <= err_count + 1;
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            if (err_count < 10)
              $display("mismatch: exp st%b wp%b rs%b f%b id%0d w%h l%b",
                       want.status, want.was_pending, want.restart, want.fired,
                       want.fired_id, want.fired_word, want.last,
                       " got st%b wp%b rs%b f%b id%0d w%h l%b",
                       got.status, got.was_pending, got.restart, got.fired,
                       got.fired_id, got.fired_word, got.last);
            err_count <= err_count + 1;
          end
        end
      end
    end
    pending_results = want_q.size();
  end
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives add, modify, delete and tick words into the timer queue with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import sotq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [103:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [39:0]  out_tdata;
  logic         out_tuser, out_tlast;
  int           err_count, pending_results, fired_total;
  int           words_sent;
  bit           calm;      // no idling on either side
  bit           hold_rx;   // long receiver hold-off
  logic         added[16]; // slots that have ever been written by add

  sorted_oneshot_timer_queue_unit uut (.*);

  sotq_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver side ready pattern
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= !hold_rx && (calm || $urandom_range(99) >= 22);
    end
  end

  // one word over the input stream, with random idle beforehand;
  // valid stays up after acceptance until the next call or the end
  task automatic send_word(input logic [1:0] kind, input logic [3:0] id,
                           input logic [31:0] ex, input logic [31:0] wd,
                           input logic [31:0] now);
    while (!calm && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    if (kind == KIND_ADD) added[id] = 1'b1;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, now, wd, ex, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // random time near a base so ticks regularly expire timers
  function automatic logic [31:0] near(input logic [31:0] base);
    return ($urandom_range(9) == 0) ? $urandom() : base + $urandom_range(60) - 20;
  endfunction

  initial begin
    logic [31:0] base;
    logic [3:0]  id;
    int          k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_ADD;
    calm = 1'b0;
    hold_rx = 1'b0;
    words_sent = 0;
    for (int i = 0; i < 16; i++) added[i] = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty tick, edge times, duplicate add, head insert, wraps
    send_word(KIND_TICK, 4'd0, 0, 0, 32'hFFFF_FFFF);
    send_word(KIND_DELETE, 4'd15, 0, 0, 0);
    send_word(KIND_ADD, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(KIND_ADD, 4'd0, 32'h0, 32'h0, 0);
    send_word(KIND_ADD, 4'd15, 32'h0, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
    send_word(KIND_ADD, 4'd7, 32'h0, 32'h1234_5678, 0);
    send_word(KIND_ADD, 4'd8, 32'h8000_0000, 32'h5555_AAAA, 0);
    send_word(KIND_MODIFY, 4'd7, 32'h7FFF_FFFF, 0, 0);
    send_word(KIND_MODIFY, 4'd8, 32'h0000_0001, 0, 0);
    send_word(KIND_DELETE, 4'd15, 0, 0, 0);
    send_word(KIND_DELETE, 4'd15, 0, 0, 0);
    send_word(KIND_TICK, 4'd0, 0, 0, 32'h0000_0001);
    send_word(KIND_TICK, 4'd0, 0, 0, 32'h8000_0000);
    send_word(KIND_TICK, 4'd0, 0, 0, 32'hFFFF_FFFF);
    send_word(KIND_MODIFY, 4'd8, 32'h10, 0, 0);
    // fill all slots, duplicate-add refusals, then one tick drains them all
    for (int i = 0; i < 16; i++)
      send_word(KIND_ADD, i[3:0], 32'h100 + $urandom_range(8), $urandom(), 0);
    send_word(KIND_ADD, 4'd3, 0, 0, 0);
    send_word(KIND_TICK, 4'd0, 0, 0, 32'h200);

    // random: mostly well-formed timer traffic with advancing time
    base = 32'hFFFF_FF00;
    k = 0;
    while (k < 150) begin
      if (k == 40) calm = 1'b1;
      if (k == 80) calm = 1'b0;
      if (k == 100) begin
        fork
          begin
            hold_rx = 1'b1;
            repeat (300) @(negedge clk);
            hold_rx = 1'b0;
          end
        join_none
      end
      id = 4'($urandom_range(15));
      case ($urandom_range(9))
        0, 1, 2: send_word(KIND_ADD, id, near(base), $urandom(), $urandom());
        3, 4: begin
          // modify only slots whose word has been written
          if (!added[id]) send_word(KIND_ADD, id, near(base), $urandom(), 0);
          else send_word(KIND_MODIFY, id, near(base), $urandom(), $urandom());
        end
        5: send_word(KIND_DELETE, id, $urandom(), $urandom(), $urandom());
        default: begin
          base = base + $urandom_range(30);
          send_word(KIND_TICK, id, $urandom(), $urandom(), near(base));
        end
      endcase
      k++;
    end
    in_tvalid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d words: add/modify/delete/tick, duplicates, full list,", words_sent);
    $display("time wrap, %0d timers fired, random gaps and a long output stall.", fired_total);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
